// File: hdl/ber_tlv_stream_validator_defines.svh
// ----------------------------------------------------------------------------
// ber_tlv_stream_validator_defines
// Assertion macros for the BER TLV stream validator
// ----------------------------------------------------------------------------
`ifndef BER_TLV_STREAM_VALIDATOR_DEFINES_SVH
`define BER_TLV_STREAM_VALIDATOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked at every edge out of reset
`define BTV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btv assertion failed");
// next-cycle implication
`define BTV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btv assertion failed");
`else
`define BTV_ASSERT_NOW(lbl, ante, cons)
`define BTV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/btv_pkg.sv
// ----------------------------------------------------------------------------
// btv_pkg
// Shared types and codes of the BER TLV stream validator
// ----------------------------------------------------------------------------
package btv_pkg;

  localparam int VERDICT_W = 3;

  localparam logic [VERDICT_W-1:0] VERDICT_OK      = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_TRUNC   = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_LOL = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DEEP    = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_POS_OVF = 3'd4;

  // command broadcast to every frame cell
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_cmd_t;

  // summary of the frame cell row
  typedef struct packed {
    logic any;
    logic full;
    logic any_nxt;
    logic top_match;
    logic top_exceeds;
  } stack_stat_t;

endpackage

// File: hdl/ber_tlv_stream_validator.sv
// ----------------------------------------------------------------------------
// ber_tlv_stream_validator
// Checks a byte stream as a sequence of BER tag-length-value elements
// ----------------------------------------------------------------------------
// Takes one byte per cycle with no gaps of its own and returns one verdict
// beat per message, registered in the cycle after the beat marked last. Open
// constructed elements live in a row of MAX_DEPTH cells, each holding one
// end position and comparing it against the current position and the
// candidate element end in the same cycle; that compare and the position
// adder set the clock-to-clock path. Input stalls only when a last beat
// arrives while the previous verdict is still held by the receiver.
`include "ber_tlv_stream_validator_defines.svh"

module ber_tlv_stream_validator #(
  parameter int MAX_DEPTH = 8,
  parameter int POS_WIDTH = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_verdict
);

  localparam logic [2:0] PH_TAG  = 3'd0;
  localparam logic [2:0] PH_TAGX = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_LENX = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;

  logic [2:0]           phase_r, phase_nxt;
  logic [1:0]           tag_ext_r, tag_ext_nxt;
  logic                 constr_r, constr_nxt;
  logic [31:0]          accum_r, accum_nxt;
  logic [2:0]           left_r, left_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] skip_end_r, skip_end_nxt;
  logic [2:0]           err_r, err_nxt;
  logic                 out_valid_r;
  logic [2:0]           out_verdict_r;

  logic                 accept;
  logic                 parse_en;
  logic [POS_WIDTH:0]   p_inc;
  logic [31:0]          accum_shift;
  logic [31:0]          cand_len;
  logic [POS_WIDTH:0]   cand_end;
  logic [2:0]           final_verdict;

  btv_pkg::stack_cmd_t  cmd;
  btv_pkg::stack_stat_t stat;

  assign in_stall = out_valid_r && out_stall && in_last_byte;
  assign accept   = in_valid && !in_stall;
  assign parse_en = accept && (err_r == btv_pkg::VERDICT_OK);

  assign p_inc       = {1'b0, pos_r} + {{POS_WIDTH{1'b0}}, 1'b1};
  assign accum_shift = {accum_r[23:0], in_data_byte};
  // short length and long-length count share the low seven bits
  assign cand_len    = (phase_r == PH_LENX) ? accum_shift : {25'd0, in_data_byte[6:0]};
  assign cand_end    = p_inc + {{(POS_WIDTH-31){1'b0}}, cand_len};

  btv_frame_chain #(
    .MAX_DEPTH (MAX_DEPTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cand_end (cand_end),
    .p_inc    (p_inc),
    .stat     (stat)
  );

  always_comb begin
    logic       do_len;
    logic       len_zero;
    logic [6:0] n;
    logic       push;
    logic       pop;
    logic [2:0] e;

    phase_nxt    = phase_r;
    tag_ext_nxt  = tag_ext_r;
    constr_nxt   = constr_r;
    accum_nxt    = accum_r;
    left_nxt     = left_r;
    pos_nxt      = pos_r;
    skip_end_nxt = skip_end_r;
    do_len       = 1'b0;
    len_zero     = 1'b0;
    n            = in_data_byte[6:0];
    push         = 1'b0;
    pop          = 1'b0;
    e            = err_r;

    if (parse_en) begin
      case (phase_r)
        PH_TAG: begin
          if (in_data_byte == 8'd0) begin
            pop = 1'b1;
          end else begin
            constr_nxt  = in_data_byte[5];
            tag_ext_nxt = 2'd0;
            phase_nxt   = (in_data_byte[4:0] == 5'h1F) ? PH_TAGX : PH_LEN;
          end
        end
        PH_TAGX: begin
          tag_ext_nxt = tag_ext_r + 2'd1;
          if (!(in_data_byte[7] && (tag_ext_nxt < 2'd3))) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (!in_data_byte[7]) begin
            do_len   = 1'b1;
            len_zero = (n == 7'd0);
          end else if ((stat.any && stat.top_exceeds) || (in_last_byte && n != 7'd0)) begin
            e = btv_pkg::VERDICT_TRUNC;
          end else if (!(n inside {7'd0, 7'd1, 7'd2, 7'd4})) begin
            e = btv_pkg::VERDICT_BAD_LOL;
          end else if (n == 7'd0) begin
            do_len   = 1'b1;
            len_zero = 1'b1;
          end else begin
            accum_nxt = 32'd0;
            left_nxt  = n[2:0];
            phase_nxt = PH_LENX;
          end
        end
        PH_LENX: begin
          accum_nxt = accum_shift;
          left_nxt  = left_r - 3'd1;
          if (left_nxt == 3'd0) begin
            do_len   = 1'b1;
            len_zero = (accum_shift == 32'd0);
          end
        end
        PH_SKIP: begin
          if (p_inc == {1'b0, skip_end_r}) begin
            pop = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (do_len) begin
        if (stat.any && stat.top_exceeds) begin
          e = btv_pkg::VERDICT_TRUNC;
        end else if (len_zero) begin
          pop = 1'b1;
        end else if (cand_end[POS_WIDTH]) begin
          e = btv_pkg::VERDICT_POS_OVF;
        end else if (constr_r) begin
          if (stat.full) begin
            e = btv_pkg::VERDICT_DEEP;
          end else begin
            push = 1'b1;
          end
        end else begin
          skip_end_nxt = cand_end[POS_WIDTH-1:0];
          phase_nxt    = PH_SKIP;
        end
      end

      if (pop || push) begin
        phase_nxt = PH_TAG;
      end

      // element still open when its enclosing frame closes
      if (e == btv_pkg::VERDICT_OK && stat.any && stat.top_match &&
          (phase_nxt inside {PH_TAGX, PH_LEN, PH_LENX})) begin
        e = btv_pkg::VERDICT_TRUNC;
      end

      if (!in_last_byte && e == btv_pkg::VERDICT_OK) begin
        if (&pos_r) begin
          e = btv_pkg::VERDICT_POS_OVF;
        end else begin
          pos_nxt = p_inc[POS_WIDTH-1:0];
        end
      end
    end

    err_nxt = e;
    if (accept && in_last_byte && e == btv_pkg::VERDICT_OK &&
        (phase_nxt != PH_TAG || stat.any_nxt)) begin
      final_verdict = btv_pkg::VERDICT_TRUNC;
    end else begin
      final_verdict = e;
    end

    cmd.push  = push;
    cmd.pop   = pop;
    cmd.clear = accept && in_last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TAG;
      tag_ext_r  <= 2'd0;
      constr_r   <= 1'b0;
      accum_r    <= 32'd0;
      left_r     <= 3'd0;
      pos_r      <= '0;
      skip_end_r <= '0;
      err_r      <= btv_pkg::VERDICT_OK;
    end else if (accept && in_last_byte) begin
      phase_r    <= PH_TAG;
      tag_ext_r  <= 2'd0;
      constr_r   <= 1'b0;
      accum_r    <= 32'd0;
      left_r     <= 3'd0;
      pos_r      <= '0;
      skip_end_r <= '0;
      err_r      <= btv_pkg::VERDICT_OK;
    end else begin
      phase_r    <= phase_nxt;
      tag_ext_r  <= tag_ext_nxt;
      constr_r   <= constr_nxt;
      accum_r    <= accum_nxt;
      left_r     <= left_nxt;
      pos_r      <= pos_nxt;
      skip_end_r <= skip_end_nxt;
      err_r      <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      out_verdict_r <= final_verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  `BTV_ASSERT_NOW(a_verdict_range, out_valid, out_verdict <= btv_pkg::VERDICT_POS_OVF)
  `BTV_ASSERT_NEXT(a_msg_end_clears, accept && in_last_byte,
                   out_valid && phase_r == PH_TAG && !stat.any && err_r == btv_pkg::VERDICT_OK)
  `BTV_ASSERT_NEXT(a_error_sticky, err_r != btv_pkg::VERDICT_OK && !(accept && in_last_byte),
                   err_r == $past(err_r) && pos_r == $past(pos_r))
  `BTV_ASSERT_NOW(a_stack_contiguous, stat.full, stat.any)

endmodule

// File: hdl/btv_frame_cell.sv
// ----------------------------------------------------------------------------
// btv_frame_cell
// One level of the open-frame stack: holds an end position and compares it
// ----------------------------------------------------------------------------
module btv_frame_cell #(
  parameter int POS_WIDTH = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  btv_pkg::stack_cmd_t    cmd,
  input  logic [POS_WIDTH:0]     cand_end,
  input  logic [POS_WIDTH:0]     p_inc,
  input  logic                   below_valid,
  input  logic                   above_valid,
  input  logic                   kill_in,
  output logic                   valid,
  output logic                   valid_nxt,
  output logic                   kill_out,
  output logic                   is_top,
  output logic                   match,
  output logic                   exceeds
);

  logic                 valid_r;
  logic [POS_WIDTH-1:0] end_r;
  logic                 slot;

  assign slot    = !valid_r && below_valid;
  assign match   = valid_r && (p_inc == {1'b0, end_r});
  assign exceeds = cand_end > {1'b0, end_r};
  assign is_top  = valid_r && !above_valid;
  // pass pop permission down only while every level above also closes here
  assign kill_out = !valid_r || (match && kill_in);
  assign valid    = valid_r;

  // occupancy after this beat's push or pop, before the end-of-message clear
  always_comb begin
    if (cmd.push && slot) begin
      valid_nxt = 1'b1;
    end else if (cmd.pop && match && kill_in) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clear) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && slot && !cmd.clear) begin
      end_r <= cand_end[POS_WIDTH-1:0];
    end
  end

endmodule

// File: hdl/btv_frame_chain.sv
// ----------------------------------------------------------------------------
// btv_frame_chain
// Row of frame cells forming the stack of open constructed elements
// ----------------------------------------------------------------------------
module btv_frame_chain #(
  parameter int MAX_DEPTH = 8,
  parameter int POS_WIDTH = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  btv_pkg::stack_cmd_t    cmd,
  input  logic [POS_WIDTH:0]     cand_end,
  input  logic [POS_WIDTH:0]     p_inc,
  output btv_pkg::stack_stat_t   stat
);

  logic [MAX_DEPTH-1:0] valid;
  logic [MAX_DEPTH-1:0] valid_nxt;
  logic [MAX_DEPTH-1:0] kill;
  logic [MAX_DEPTH-1:0] is_top;
  logic [MAX_DEPTH-1:0] match;
  logic [MAX_DEPTH-1:0] exceeds;
  logic [MAX_DEPTH-1:0] below_valid;
  logic [MAX_DEPTH-1:0] above_valid;
  logic [MAX_DEPTH-1:0] kill_in;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_bottom
      assign below_valid[i] = 1'b1;
    end else begin : g_mid_b
      assign below_valid[i] = valid[i-1];
    end
    if (i == MAX_DEPTH - 1) begin : g_last
      assign above_valid[i] = 1'b0;
      assign kill_in[i]     = 1'b1;
    end else begin : g_mid_a
      assign above_valid[i] = valid[i+1];
      assign kill_in[i]     = kill[i+1];
    end

    btv_frame_cell #(
      .POS_WIDTH (POS_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .cand_end    (cand_end),
      .p_inc       (p_inc),
      .below_valid (below_valid[i]),
      .above_valid (above_valid[i]),
      .kill_in     (kill_in[i]),
      .valid       (valid[i]),
      .valid_nxt   (valid_nxt[i]),
      .kill_out    (kill[i]),
      .is_top      (is_top[i]),
      .match       (match[i]),
      .exceeds     (exceeds[i])
    );
  end

  assign stat.any         = valid[0];
  assign stat.full        = valid[MAX_DEPTH-1];
  assign stat.any_nxt     = valid_nxt[0];
  assign stat.top_match   = |(is_top & match);
  assign stat.top_exceeds = |(is_top & exceeds);

endmodule

// File: test/ber_tlv_stream_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_stream_validator_tb
// Self-checking bench for the BER TLV stream validator
// ----------------------------------------------------------------------------
// Drives whole messages a byte per beat, starting with a short hand-written
// set (end-of-contents, unfinished tag, bad length-of-length, over-deep
// nesting, long-form count on the last byte) and then random messages built
// as well-formed TLV trees, some damaged, some pure noise. Every accepted
// byte runs through a local parser model; each verdict beat is compared
// with the oldest predicted verdict. Sender gaps and receiver stalls vary
// by phase.
// ----------------------------------------------------------------------------
module ber_tlv_stream_validator_tb;

  localparam int          DEPTH    = 8;
  localparam int          POS_W    = 40;
  localparam logic [63:0] POS_LAST = (64'd1 << POS_W) - 64'd1;
  localparam int          PHASE_BYTES = 320;

  localparam logic [4:0] TAG_NUM_ESC     = 5'h1F;
  localparam logic [7:0] LEN_LONG_FORM   = 8'h80;
  localparam logic [7:0] END_OF_CONTENTS = 8'h00;
  localparam logic [7:0] SEQ_TAG         = 8'h30;
  localparam logic [7:0] PRIM_TAG        = 8'h04;
  localparam logic [7:0] ALL_ONES        = 8'hFF;

  typedef enum logic [2:0] {
    SCAN_TAG,
    SCAN_TAG_EXT,
    SCAN_LEN,
    SCAN_LEN_EXT,
    SCAN_SKIP
  } scan_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [2:0] verdict;
  } dir_row_t;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [2:0] out_verdict;

  ber_tlv_stream_validator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_verdict  (out_verdict)
  );

  // parser model state
  scan_t       scan;
  logic [1:0]  ext_cnt;
  logic        is_cons;
  logic [31:0] len_acc;
  logic [2:0]  len_left;
  logic [63:0] pos;
  logic [63:0] skip_end;
  logic [63:0] open_ends [DEPTH];
  int          open_cnt;
  logic [2:0]  err_code;

  logic [2:0] verdict_q [$];
  logic [2:0] want_verdict;
  int         verdict_hits [5];
  int         fail_count = 0;
  int         msg_cnt    = 0;
  int         beat_cnt   = 0;
  int         gap_pct    = 0;
  int         stall_pct  = 0;

  // 25 beats: five messages
  dir_row_t dir_rows [25] = '{
    '{END_OF_CONTENTS, 1'b1, 1'b1, btv_pkg::VERDICT_OK},
    '{ALL_ONES,        1'b1, 1'b1, btv_pkg::VERDICT_TRUNC},
    '{PRIM_TAG,        1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'h83,           1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'h00,           1'b1, 1'b1, btv_pkg::VERDICT_BAD_LOL},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd17,           1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd15,           1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd13,           1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd11,           1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd9,            1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd7,            1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd5,            1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd3,            1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{SEQ_TAG,         1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'd1,            1'b1, 1'b1, btv_pkg::VERDICT_DEEP},
    '{PRIM_TAG,        1'b0, 1'b0, btv_pkg::VERDICT_OK},
    '{8'h82,           1'b1, 1'b1, btv_pkg::VERDICT_TRUNC}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d verdicts outstanding", verdict_q.size());
    $display("[ber_tlv_stream_validator] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic void clear_scan();
    scan     = SCAN_TAG;
    ext_cnt  = 2'd0;
    is_cons  = 1'b0;
    len_acc  = 32'd0;
    len_left = 3'd0;
    pos      = 64'd0;
    skip_end = 64'd0;
    open_cnt = 0;
    err_code = btv_pkg::VERDICT_OK;
  endfunction

  // first error sticks
  function automatic void flag(input logic [2:0] code);
    if (err_code == btv_pkg::VERDICT_OK) err_code = code;
  endfunction

  function automatic logic [63:0] room_left(input logic [63:0] p);
    logic [63:0] top;
    top = open_ends[open_cnt-1];
    return (top > p) ? top - p - 64'd1 : 64'd0;
  endfunction

  function automatic void close_element(input logic [63:0] p);
    scan = SCAN_TAG;
    while (open_cnt > 0 && open_ends[open_cnt-1] == p + 64'd1) open_cnt--;
  endfunction

  function automatic void finish_length(input logic [63:0] p, input logic [63:0] len);
    if (open_cnt > 0 && len > room_left(p)) begin
      flag(btv_pkg::VERDICT_TRUNC);
      return;
    end
    if (len == 64'd0) begin
      close_element(p);
      return;
    end
    if (len >= POS_LAST - p) begin
      flag(btv_pkg::VERDICT_POS_OVF);
      return;
    end
    if (is_cons) begin
      if (open_cnt >= DEPTH) begin
        flag(btv_pkg::VERDICT_DEEP);
        return;
      end
      open_ends[open_cnt] = p + 64'd1 + len;
      open_cnt++;
      scan = SCAN_TAG;
    end else begin
      skip_end = p + 64'd1 + len;
      scan = SCAN_SKIP;
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic lst);
    logic [63:0] p;
    logic [6:0]  n;
    p = pos;
    case (scan)
      SCAN_TAG: begin
        if (b == END_OF_CONTENTS) begin
          close_element(p);
        end else begin
          is_cons = b[5];
          ext_cnt = 2'd0;
          scan = (b[4:0] == TAG_NUM_ESC) ? SCAN_TAG_EXT : SCAN_LEN;
        end
      end
      SCAN_TAG_EXT: begin
        ext_cnt++;
        if (!(b[7] && ext_cnt < 2'd3)) scan = SCAN_LEN;
      end
      SCAN_LEN: begin
        n = b[6:0];
        if (!b[7]) begin
          finish_length(p, {57'd0, n});
        end else if ((open_cnt > 0 && n > room_left(p)) || (lst && n != 7'd0)) begin
          flag(btv_pkg::VERDICT_TRUNC);
        end else if (n != 7'd0 && n != 7'd1 && n != 7'd2 && n != 7'd4) begin
          flag(btv_pkg::VERDICT_BAD_LOL);
        end else if (n == 7'd0) begin
          finish_length(p, 64'd0);
        end else begin
          len_acc  = 32'd0;
          len_left = n[2:0];
          scan     = SCAN_LEN_EXT;
        end
      end
      SCAN_LEN_EXT: begin
        len_acc = {len_acc[23:0], b};
        len_left--;
        if (len_left == 3'd0) finish_length(p, {32'd0, len_acc});
      end
      default: begin
        if (p + 64'd1 == skip_end) close_element(p);
      end
    endcase
    // header still open when the enclosing frame runs out
    if (err_code == btv_pkg::VERDICT_OK && open_cnt > 0 &&
        (scan == SCAN_TAG_EXT || scan == SCAN_LEN || scan == SCAN_LEN_EXT) &&
        open_ends[open_cnt-1] == p + 64'd1)
      flag(btv_pkg::VERDICT_TRUNC);
  endfunction

  function automatic void take_beat(input logic [7:0] b, input logic lst,
                                    output logic done, output logic [2:0] v);
    if (err_code == btv_pkg::VERDICT_OK) scan_byte(b, lst);
    done = lst;
    v = btv_pkg::VERDICT_OK;
    if (!lst) begin
      if (err_code == btv_pkg::VERDICT_OK) begin
        if (pos >= POS_LAST) flag(btv_pkg::VERDICT_POS_OVF);
        else pos++;
      end
      return;
    end
    if (err_code == btv_pkg::VERDICT_OK && (scan != SCAN_TAG || open_cnt != 0))
      flag(btv_pkg::VERDICT_TRUNC);
    v = err_code;
    clear_scan();
  endfunction

  function automatic void emit_tag(input logic cons, inout logic [7:0] q[$]);
    logic [7:0] t;
    logic [7:0] c;
    int n;
    int i;
    t = 8'($urandom);
    t[5] = cons;
    if ($urandom_range(3) == 0) begin
      t[4:0] = TAG_NUM_ESC;
      q.push_back(t);
      n = $urandom_range(1, 3);
      for (i = 1; i <= n; i++) begin
        c = 8'($urandom);
        // the third continuation ends the tag whatever its top bit
        if (i < n) c[7] = 1'b1;
        else if (i < 3) c[7] = 1'b0;
        q.push_back(c);
      end
    end else begin
      if (t[4:0] == TAG_NUM_ESC) t[4:0] = 5'h1E;
      if (t == END_OF_CONTENTS) t = 8'h02;
      q.push_back(t);
    end
  endfunction

  function automatic void emit_length(input int unsigned len, inout logic [7:0] q[$]);
    int unsigned form;
    form = $urandom_range(9);
    if (len < 128 && form < 5) begin
      q.push_back(len[7:0]);
    end else if (len == 0 && form < 7) begin
      q.push_back(LEN_LONG_FORM);
    end else if (len < 256 && form < 8) begin
      q.push_back(LEN_LONG_FORM | 8'd1);
      q.push_back(len[7:0]);
    end else if (len < 65536 && form < 9) begin
      q.push_back(LEN_LONG_FORM | 8'd2);
      q.push_back(len[15:8]);
      q.push_back(len[7:0]);
    end else begin
      q.push_back(LEN_LONG_FORM | 8'd4);
      q.push_back(len[31:24]);
      q.push_back(len[23:16]);
      q.push_back(len[15:8]);
      q.push_back(len[7:0]);
    end
  endfunction

  // well-formed element sequence, nested up to just past the depth limit
  function automatic void gen_elems(input int lvl, input int budget,
                                    inout logic [7:0] q[$]);
    logic [7:0] body [$];
    int k;
    int cnt;
    int pick;
    cnt = $urandom_range(1, 3);
    for (k = 0; k < cnt; k++) begin
      body.delete();
      pick = $urandom_range(9);
      if (pick == 0) begin
        q.push_back(END_OF_CONTENTS);
      end else begin
        if (pick < 5) begin
          if (lvl <= DEPTH && budget > 2) gen_elems(lvl + 1, budget / 2, body);
        end else begin
          repeat ($urandom_range(0, budget < 6 ? budget : 6)) body.push_back(8'($urandom));
        end
        emit_tag(pick < 5, q);
        emit_length(body.size(), q);
        foreach (body[j]) q.push_back(body[j]);
      end
    end
  endfunction

  function automatic void damage(inout logic [7:0] q[$]);
    int k;
    case ($urandom_range(4))
      0: begin
        k = $urandom_range(q.size() - 1);
        q[k] = 8'($urandom);
      end
      1: begin
        k = $urandom_range(q.size() - 1);
        q[k] = q[k] ^ (8'h01 << $urandom_range(7));
      end
      2: begin
        k = $urandom_range(1, q.size());
        while (q.size() > k) void'(q.pop_back());
      end
      3: q.push_back(8'($urandom));
      default: begin
        q.delete();
        repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
      end
    endcase
  endfunction

  task automatic drive_beat(input logic [7:0] b, input logic lst,
                            input logic typed, input logic [2:0] typed_v);
    logic       done;
    logic [2:0] v;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_beat(b, lst, done, v);
    beat_cnt++;
    if (done) begin
      verdict_q.push_back(typed ? typed_v : v);
      msg_cnt++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  // verdict beats
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with none predicted", out_verdict));
      end else begin
        want_verdict = verdict_q.pop_front();
        if (out_verdict !== want_verdict)
          report_mismatch($sformatf("verdict %0d, predicted %0d", out_verdict,
                                    want_verdict));
        else if (want_verdict < 3'd5)
          verdict_hits[want_verdict]++;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    logic [7:0] msg [$];
    int         ph;
    int         phase_start;
    int         i;
    int         gap_tab [4];
    int         stall_tab [4];
    gap_tab   = '{0, 63, 0, 31};
    stall_tab = '{0, 0, 63, 31};
    foreach (verdict_hits[k]) verdict_hits[k] = 0;
    clear_scan();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      drive_beat(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed,
                 dir_rows[r].verdict);

    for (ph = 0; ph < 4; ph++) begin
      // hold off until every verdict of the last phase is in
      wait_drained();
      gap_pct     = gap_tab[ph];
      stall_pct   = stall_tab[ph];
      phase_start = beat_cnt;
      while (beat_cnt - phase_start < PHASE_BYTES) begin
        msg.delete();
        gen_elems(0, $urandom_range(4, 30), msg);
        if ($urandom_range(99) < 25) damage(msg);
        for (i = 0; i < msg.size(); i++)
          drive_beat(msg[i], i == msg.size() - 1, 1'b0, btv_pkg::VERDICT_OK);
      end
    end

    gap_pct   = 0;
    stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("ran %0d messages in %0d beats under four gap/stall mixes", msg_cnt,
             beat_cnt);
    $display("verdicts matched: valid %0d, truncated %0d, bad count %0d, deep %0d",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
    if (fail_count == 0)
      $display("[ber_tlv_stream_validator] OK");
    else
      $display("[ber_tlv_stream_validator] ERROR");
    $finish;
  end

endmodule

// File: ber_tlv_stream_validator.f
+incdir+hdl
hdl/btv_pkg.sv
hdl/btv_frame_cell.sv
hdl/btv_frame_chain.sv
hdl/ber_tlv_stream_validator.sv
test/ber_tlv_stream_validator_tb.sv
